// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL; the controller (fhp_ctrl) includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, checked on every rising clock edge out of reset.
`define CHK_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
// Next-cycle implication.
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`endif

// ===== rtl/core/fhp_pkg.sv =====
// Package: types, constants and the CORDIC arctangent table for the proximity check.
`timescale 1ns / 1ps
package fhp_pkg;

  localparam int MAX_CIRCLES_DEF  = 4;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int STEP_W           = 5;   // iteration index, steps up to 24
  localparam int CIRC_W           = 2;   // four circle registers
  localparam int CW               = 40;  // CORDIC x/y and position width
  localparam int ZW               = 34;  // CORDIC angle accumulator
  localparam int PW               = 72;  // multiplier product
  localparam int RW               = 42;  // distance minus radius
  localparam int ADDR_W           = 6;
  localparam int DATA_W           = 64;

  localparam logic [31:0] GAIN_Q30 = 32'd652032874;
  localparam logic signed [23:0] CLR_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] CLR_MIN = -24'sh800000;

  localparam logic [2:0] REG_COUNT = 3'd0;
  localparam logic [2:0] REG_SCALE = 3'd1;
  localparam logic [2:0] REG_CIRA  = 3'd2;
  localparam logic [2:0] REG_CIRB  = 3'd3;
  localparam logic [2:0] REG_CIRC  = 3'd4;
  localparam logic [2:0] REG_CIRD  = 3'd5;
  localparam logic [2:0] REG_HRAD  = 3'd6;
  localparam logic [2:0] REG_FLOOR = 3'd7;

  typedef struct packed {
    logic signed [15:0] robot_x;
    logic signed [15:0] robot_y;
    logic [15:0]        robot_heading;
    logic signed [15:0] human_x;
    logic signed [15:0] human_y;
    logic [15:0]        human_heading;
    logic               last_human;
  } in_item_t;

  typedef struct packed {
    logic               collides;
    logic               any_collision;
    logic signed [23:0] min_clearance;
    logic               set_done;
  } out_item_t;

  typedef struct packed {
    logic [2:0]       circle_count;
    logic [15:0]      footprint_scale;
    logic [3:0][47:0] circle;
    logic [15:0]      human_radius;
    logic [15:0]      contraction_floor;
  } cfg_t;

  typedef enum logic [1:0] {COR_ROT, COR_POL, COR_SIN} cor_sel_t;
  typedef enum logic [2:0] {MUL_XG, MUL_YG, MUL_PX, MUL_PY, MUL_MAG} mul_sel_t;

  typedef struct packed {
    logic              load_item;
    logic              cor_load;
    cor_sel_t          cor_sel;
    logic              cor_step;
    logic              cor_polar;
    logic [STEP_W-1:0] idx;
    logic              mul_en;
    logic [1:0]        mul_ph;
    mul_sel_t          mul_sel;
    logic              reach_load;
    logic              con_load;
    logic              hc_load;
    logic              cmp;
    logic [CIRC_W-1:0] circ;
    logic              finish;
  } cmd_t;

  // atan(2^-i) in 2^32 units per turn
  function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/footprint_human_proximity_check.sv =====
// Top level: robot footprint against one human per item, running set summary.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready  | in_data  (fhp_pkg::in_item_t)
//  out     | output    | out_valid/out_ready| out_data (fhp_pkg::out_item_t)
//  cfg     | input     | psel/penable/pwrite| paddr, pwdata, prdata (64-bit registers)
//
// Each circle in use, up to MAX_CIRCLES, goes in turn through the single shared CORDIC
// unit (rotation, polar and sine pass) and the two-half multiplier.
// Items are taken one at a time; the result register frees the input side while an
// item waits at the output. Synchronous reset clears the set state, no clearing pass.
`timescale 1ns / 1ps
module footprint_human_proximity_check #(
  parameter int MAX_CIRCLES  = fhp_pkg::MAX_CIRCLES_DEF,
  parameter int CORDIC_STEPS = fhp_pkg::CORDIC_STEPS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  fhp_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output fhp_pkg::out_item_t         out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fhp_pkg::ADDR_W-1:0] paddr,
  input  logic [fhp_pkg::DATA_W-1:0] pwdata,
  output logic [fhp_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  fhp_pkg::cfg_t cfg;
  fhp_pkg::cmd_t cmd;

  fhp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fhp_ctrl #(
    .MAX_CIRCLES  (MAX_CIRCLES),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .circle_count (cfg.circle_count),
    .cmd          (cmd)
  );

  fhp_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cfg      (cfg),
    .cmd      (cmd),
    .out_data (out_data)
  );

endmodule

// ===== rtl/core/fhp_regs.sv =====
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
module fhp_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fhp_pkg::ADDR_W-1:0]    paddr,
  input  logic [fhp_pkg::DATA_W-1:0]    pwdata,
  output logic [fhp_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output fhp_pkg::cfg_t                 cfg
);

  logic [2:0] ridx;
  logic       wr;

  assign ridx   = paddr[5:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.circle_count      <= 3'd1;
      cfg.footprint_scale   <= 16'd256;
      cfg.circle[0]         <= 48'd256;
      cfg.circle[1]         <= 48'd0;
      cfg.circle[2]         <= 48'd0;
      cfg.circle[3]         <= 48'd0;
      cfg.human_radius      <= 16'd128;
      cfg.contraction_floor <= 16'd6554;
    end else if (wr) begin
      case (ridx)
        fhp_pkg::REG_COUNT: cfg.circle_count      <= pwdata[2:0];
        fhp_pkg::REG_SCALE: cfg.footprint_scale   <= pwdata[15:0];
        fhp_pkg::REG_CIRA:  cfg.circle[0]         <= pwdata[47:0];
        fhp_pkg::REG_CIRB:  cfg.circle[1]         <= pwdata[47:0];
        fhp_pkg::REG_CIRC:  cfg.circle[2]         <= pwdata[47:0];
        fhp_pkg::REG_CIRD:  cfg.circle[3]         <= pwdata[47:0];
        fhp_pkg::REG_HRAD:  cfg.human_radius      <= pwdata[15:0];
        fhp_pkg::REG_FLOOR: cfg.contraction_floor <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      fhp_pkg::REG_COUNT: prdata = {61'd0, cfg.circle_count};
      fhp_pkg::REG_SCALE: prdata = {48'd0, cfg.footprint_scale};
      fhp_pkg::REG_CIRA:  prdata = {16'd0, cfg.circle[0]};
      fhp_pkg::REG_CIRB:  prdata = {16'd0, cfg.circle[1]};
      fhp_pkg::REG_CIRC:  prdata = {16'd0, cfg.circle[2]};
      fhp_pkg::REG_CIRD:  prdata = {16'd0, cfg.circle[3]};
      fhp_pkg::REG_HRAD:  prdata = {48'd0, cfg.human_radius};
      fhp_pkg::REG_FLOOR: prdata = {48'd0, cfg.contraction_floor};
      default:            prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/fhp_dp.sv =====
// Datapath: shared CORDIC unit, split multiplier, clearance and collision test.
`timescale 1ns / 1ps
module fhp_dp (
  input  logic                clk,
  input  logic                rst,
  input  fhp_pkg::in_item_t   in_data,
  input  fhp_pkg::cfg_t       cfg,
  input  fhp_pkg::cmd_t       cmd,
  output fhp_pkg::out_item_t  out_data
);

  localparam int CW = fhp_pkg::CW;
  localparam int ZW = fhp_pkg::ZW;
  localparam int PW = fhp_pkg::PW;
  localparam int RW = fhp_pkg::RW;

  fhp_pkg::in_item_t item;
  logic signed [ZW-1:0] zr;
  logic                 flip;
  logic signed [CW-1:0] cx, cy;
  logic signed [ZW-1:0] cz;
  logic signed [CW-1:0] xg, yg, pcx, pcy, mag;
  logic signed [52:0]   plo;
  logic signed [51:0]   phi;
  logic signed [PW-1:0] prod;
  logic [31:0]          rad;
  logic signed [RW-1:0] reach;
  logic [16:0]          con;
  logic [32:0]          hc;
  logic signed [23:0]   best, running_min;
  logic                 hit, running_hit;

  // heading fold into one half turn
  logic signed [ZW-1:0] zr_next;
  logic                 flip_next;
  always_comb begin
    zr_next   = ZW'($signed({in_data.robot_heading, 16'd0}));
    flip_next = 1'b0;
    if (zr_next > ZW'(34'sh40000000)) begin
      zr_next   = zr_next - ZW'(34'sh80000000);
      flip_next = 1'b1;
    end else if (zr_next < -ZW'(34'sh40000000)) begin
      zr_next   = zr_next + ZW'(34'sh80000000);
      flip_next = 1'b1;
    end
  end

  // CORDIC iteration and load values
  logic [47:0]          creg;
  logic signed [CW-1:0] xs, ys, lx, ly, dx, dy, rxp, ryp, hxp, hyp;
  logic signed [ZW-1:0] at, lz;
  logic [31:0]          d0, dd;
  logic                 dir;
  always_comb begin
    creg = cfg.circle[cmd.circ];
    xs   = cx >>> cmd.idx;
    ys   = cy >>> cmd.idx;
    at   = ZW'(fhp_pkg::atan_turn(cmd.idx));
    dir  = cmd.cor_polar ? (cy >= 0) : (cz >= 0);
    rxp  = CW'(item.robot_x) <<< 8;
    ryp  = CW'(item.robot_y) <<< 8;
    hxp  = CW'(item.human_x) <<< 8;
    hyp  = CW'(item.human_y) <<< 8;
    dx   = pcx - hxp;
    dy   = pcy - hyp;
    d0   = {item.human_heading, 16'd0} - cz[31:0];
    dd   = (d0 > 32'h80000000) ? (32'd0 - d0) : d0;
    lx   = '0;
    ly   = '0;
    lz   = '0;
    case (cmd.cor_sel)
      fhp_pkg::COR_ROT: begin
        lx = CW'($signed(creg[47:32])) <<< 16;
        ly = CW'($signed(creg[31:16])) <<< 16;
        if (flip) begin
          lx = -lx;
          ly = -ly;
        end
        lz = zr;
      end
      fhp_pkg::COR_POL: begin
        lx = dx;
        ly = dy;
        if (dx < 0) begin
          lx = -dx;
          ly = -dy;
          lz = ZW'(34'sh80000000);
        end
      end
      fhp_pkg::COR_SIN: begin
        lx = CW'(fhp_pkg::GAIN_Q30);
        lz = ZW'({1'b0, dd[31:1]});
      end
      default: ;
    endcase
  end

  // multiplier operands: a is split in two 20-bit halves, multiplied in successive phases
  logic signed [CW-1:0] ma;
  logic signed [31:0]   mb;
  always_comb begin
    case (cmd.mul_sel)
      fhp_pkg::MUL_XG:  begin ma = cx; mb = $signed(fhp_pkg::GAIN_Q30); end
      fhp_pkg::MUL_YG:  begin ma = cy; mb = $signed(fhp_pkg::GAIN_Q30); end
      fhp_pkg::MUL_PX:  begin ma = xg; mb = $signed({16'd0, cfg.footprint_scale}); end
      fhp_pkg::MUL_PY:  begin ma = yg; mb = $signed({16'd0, cfg.footprint_scale}); end
      default:          begin ma = cx; mb = $signed(fhp_pkg::GAIN_Q30); end
    endcase
  end

  // contraction and clearance
  logic signed [CW-1:0] sr;
  logic [16:0]          con_next;
  logic signed [RW-1:0] cl;
  logic signed [23:0]   clr;
  always_comb begin
    sr = (cy + CW'(8192)) >>> 14;
    if (sr < 0)
      con_next = 17'd0;
    else if (sr > CW'(65536))
      con_next = 17'd65536;
    else
      con_next = sr[16:0];
    if (con_next < {1'b0, cfg.contraction_floor})
      con_next = {1'b0, cfg.contraction_floor};
    cl = (reach - $signed(RW'({cfg.human_radius, 8'd0}))) >>> 8;
    if (cl > RW'(fhp_pkg::CLR_MAX))
      clr = fhp_pkg::CLR_MAX;
    else if (cl < RW'(fhp_pkg::CLR_MIN))
      clr = fhp_pkg::CLR_MIN;
    else
      clr = cl[23:0];
  end

  logic signed [49:0] reach_sh;
  assign reach_sh = 50'(reach) <<< 8;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_data;
      zr   <= zr_next;
      flip <= flip_next;
    end
    if (cmd.cor_load) begin
      cx <= lx;
      cy <= ly;
      cz <= lz;
      if (cmd.cor_sel == fhp_pkg::COR_ROT)
        rad <= creg[15:0] * cfg.footprint_scale;
    end else if (cmd.cor_step) begin
      if (dir == cmd.cor_polar) begin
        // polar with y >= 0, or turn with z < 0
        cx <= cx + ys;
        cy <= cy - xs;
      end else begin
        cx <= cx - ys;
        cy <= cy + xs;
      end
      if (dir)
        cz <= cmd.cor_polar ? cz + at : cz - at;
      else
        cz <= cmd.cor_polar ? cz - at : cz + at;
    end
    if (cmd.mul_en) begin
      case (cmd.mul_ph)
        2'd0: plo  <= $signed({1'b0, ma[19:0]}) * mb;
        2'd1: phi  <= $signed(ma[CW-1:20]) * mb;
        2'd2: prod <= (PW'(phi) <<< 20) + PW'(plo);
        default: begin
          case (cmd.mul_sel)
            fhp_pkg::MUL_XG: xg   <= CW'(prod >>> 30);
            fhp_pkg::MUL_YG: yg   <= CW'(prod >>> 30);
            fhp_pkg::MUL_PX: pcx  <= CW'(prod >>> 16) + rxp;
            fhp_pkg::MUL_PY: pcy  <= CW'(prod >>> 16) + ryp;
            default:         mag  <= CW'(prod >>> 30);
          endcase
        end
      endcase
    end
    if (cmd.reach_load)
      reach <= RW'(mag) - RW'({1'b0, rad});
    if (cmd.con_load)
      con <= con_next;
    if (cmd.hc_load)
      hc <= cfg.human_radius * con;
  end

  // per-item and per-set state
  always_ff @(posedge clk) begin
    if (rst) begin
      running_min <= fhp_pkg::CLR_MAX;
      running_hit <= 1'b0;
      best        <= fhp_pkg::CLR_MAX;
      hit         <= 1'b0;
    end else begin
      if (cmd.load_item) begin
        best <= running_min;
        hit  <= 1'b0;
      end
      if (cmd.con_load && (clr < best))
        best <= clr;
      if (cmd.cmp && (reach_sh < $signed({17'd0, hc})))
        hit <= 1'b1;
      if (cmd.finish) begin
        if (item.last_human) begin
          running_min <= fhp_pkg::CLR_MAX;
          running_hit <= 1'b0;
        end else begin
          running_min <= best;
          running_hit <= running_hit | hit;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data.collides      <= hit;
      out_data.any_collision <= running_hit | hit;
      out_data.min_clearance <= best;
      out_data.set_done      <= item.last_human;
    end
  end

endmodule

// ===== rtl/core/fhp_ctrl.sv =====
// Controller: sequences rotation, polar, sine and compare per footprint circle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fhp_ctrl #(
  parameter int MAX_CIRCLES  = fhp_pkg::MAX_CIRCLES_DEF,
  parameter int CORDIC_STEPS = fhp_pkg::CORDIC_STEPS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  logic [2:0]    circle_count,
  output fhp_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_ROT_LD, S_ROT, S_MUL, S_POL_LD, S_POL,
    S_SIN_LD, S_SIN, S_CON, S_HC, S_CMP, S_DONE
  } state_t;

  state_t                     state;
  logic [fhp_pkg::STEP_W-1:0] idx;
  logic [1:0]                 ph;
  fhp_pkg::mul_sel_t          msel;
  logic [fhp_pkg::CIRC_W-1:0] circ;

  logic [2:0] cnt_eff;
  logic       last_circ, last_step, slot_free;

  always_comb begin
    cnt_eff = circle_count;
    if (cnt_eff == 3'd0)
      cnt_eff = 3'd1;
    if (cnt_eff > 3'(MAX_CIRCLES))
      cnt_eff = 3'(MAX_CIRCLES);
  end

  assign last_circ = ({1'b0, circ} == (cnt_eff - 3'd1));
  assign last_step = (idx == fhp_pkg::STEP_W'(CORDIC_STEPS - 1));
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      ph        <= '0;
      msel      <= fhp_pkg::MUL_XG;
      circ      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && slot_free)
        out_valid <= 1'b1;
      else if (out_ready)
        out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            circ  <= '0;
            state <= S_ROT_LD;
          end
        end
        S_ROT_LD: begin
          idx   <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          idx <= idx + 1'b1;
          if (last_step) begin
            msel  <= fhp_pkg::MUL_XG;
            ph    <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          ph <= ph + 1'b1;
          if (ph == 2'd3) begin
            case (msel)
              fhp_pkg::MUL_XG: msel <= fhp_pkg::MUL_YG;
              fhp_pkg::MUL_YG: msel <= fhp_pkg::MUL_PX;
              fhp_pkg::MUL_PX: msel <= fhp_pkg::MUL_PY;
              fhp_pkg::MUL_PY: state <= S_POL_LD;
              default:         state <= S_SIN_LD;
            endcase
          end
        end
        S_POL_LD: begin
          idx   <= '0;
          state <= S_POL;
        end
        S_POL: begin
          idx <= idx + 1'b1;
          if (last_step) begin
            msel  <= fhp_pkg::MUL_MAG;
            ph    <= '0;
            state <= S_MUL;
          end
        end
        S_SIN_LD: begin
          idx   <= '0;
          state <= S_SIN;
        end
        S_SIN: begin
          idx <= idx + 1'b1;
          if (last_step)
            state <= S_CON;
        end
        S_CON: state <= S_HC;
        S_HC:  state <= S_CMP;
        S_CMP: begin
          if (last_circ) begin
            state <= S_DONE;
          end else begin
            circ  <= circ + 1'b1;
            state <= S_ROT_LD;
          end
        end
        S_DONE: begin
          if (slot_free)
            state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.idx        = idx;
    cmd.circ       = circ;
    cmd.mul_ph     = ph;
    cmd.mul_sel    = msel;
    cmd.cor_sel    = fhp_pkg::COR_ROT;
    cmd.load_item  = (state == S_IDLE) && in_valid;
    case (state)
      S_ROT_LD: cmd.cor_load = 1'b1;
      S_ROT:    cmd.cor_step = 1'b1;
      S_MUL:    cmd.mul_en   = 1'b1;
      S_POL_LD: begin
        cmd.cor_load = 1'b1;
        cmd.cor_sel  = fhp_pkg::COR_POL;
      end
      S_POL: begin
        cmd.cor_step  = 1'b1;
        cmd.cor_polar = 1'b1;
      end
      S_SIN_LD: begin
        cmd.cor_load   = 1'b1;
        cmd.cor_sel    = fhp_pkg::COR_SIN;
        cmd.reach_load = 1'b1;
      end
      S_SIN:  cmd.cor_step = 1'b1;
      S_CON:  cmd.con_load = 1'b1;
      S_HC:   cmd.hc_load  = 1'b1;
      S_CMP:  cmd.cmp      = 1'b1;
      S_DONE: cmd.finish   = slot_free;
      default: ;
    endcase
  end

  `CHK_NEXT(a_accept_starts, clk, rst, in_valid && in_ready, state == S_ROT_LD)
  `CHK_IMPL(a_finish_slot, clk, rst, cmd.finish, !out_valid || out_ready)
  `CHK_NEXT(a_finish_shows, clk, rst, cmd.finish, out_valid)
  `CHK_NEXT(a_mag_to_sine, clk, rst, state == S_MUL && ph == 2'd3 && msel == fhp_pkg::MUL_MAG, state == S_SIN_LD)

endmodule
